// File: rtl/core/vud_pkg.sv
package vud_pkg;

   // item field widths
   localparam int KIND_W     = 2;
   localparam int ROW_W      = 9;
   localparam int COL_W      = 10;
   localparam int DISP_W     = 9;
   localparam int COUNT_W    = 16;
   localparam int BYTE_W     = 8;

   // config port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int LEVELS_W   = 8;
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 10;

   localparam logic [LEVELS_W-1:0] LEVELS_RST = 8'd64;
   localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 10'd480;

   localparam logic [CSR_IDX_W-1:0] CSR_LEVELS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ_V = 2'd2;
   localparam logic [KIND_W-1:0] KIND_READ_U = 2'd3;

   // store geometry defaults
   localparam int DEF_MAX_ROWS   = 512;
   localparam int DEF_MAX_COLS   = 1024;
   localparam int DEF_MAX_LEVELS = 128;

   localparam int CMD_FIFO_DEPTH = 2;

   // decoded command handed from front to back
   typedef enum logic [2:0] {
      OP_CLEAR,
      OP_BUMP,
      OP_READ_V,
      OP_READ_U,
      OP_REJECT
   } op_type;

   function automatic logic [COUNT_W-1:0] bump_sat(input logic [COUNT_W-1:0] c);
      return (c == {COUNT_W{1'b1}}) ? c : c + 1'b1;
   endfunction

   function automatic logic [BYTE_W-1:0] byte_sat(input logic [COUNT_W-1:0] c);
      return (c > COUNT_W'(255)) ? {BYTE_W{1'b1}} : c[BYTE_W-1:0];
   endfunction

endpackage

// File: rtl/core/vud_ifs.sv
interface vud_req_if;
   import vud_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic [ROW_W-1:0]         row;
   logic [COL_W-1:0]         column;
   logic signed [DISP_W-1:0] disparity;
   modport source (output valid, kind, row, column, disparity, input ready);
   modport sink   (input valid, kind, row, column, disparity, output ready);
endinterface

interface vud_rsp_if;
   import vud_pkg::*;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] bin_count;
   logic [BYTE_W-1:0]  bin_byte;
   logic               status;
   modport source (output valid, bin_count, bin_byte, status, input ready);
   modport sink   (input valid, bin_count, bin_byte, status, output ready);
endinterface

interface vud_csr_if;
   import vud_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/vud_front.sv
module vud_front #(
   parameter int MAX_ROWS   = vud_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS   = vud_pkg::DEF_MAX_COLS,
   parameter int MAX_LEVELS = vud_pkg::DEF_MAX_LEVELS,
   localparam int VA_W = $clog2(MAX_ROWS * MAX_LEVELS),
   localparam int UA_W = $clog2(MAX_COLS * MAX_LEVELS)
) (
   input  logic             clock,
   input  logic             reset,
   vud_req_if.sink          req_ch,
   vud_csr_if.sink          csr_ch,
   input  logic             init_busy,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output vud_pkg::op_type  cmd_op,
   output logic [VA_W-1:0]  cmd_v_addr,
   output logic [UA_W-1:0]  cmd_u_addr
);
   import vud_pkg::*;

   localparam int L_W = $clog2(MAX_LEVELS + 1);
   localparam int W_W = $clog2(MAX_COLS + 1);
   localparam int H_W = $clog2(MAX_ROWS + 1);
   localparam int B_W = $clog2(MAX_LEVELS);

   logic [LEVELS_W-1:0] levels_ff;
   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;

   logic [L_W-1:0]      levels_eff;
   logic [W_W-1:0]      width_eff;
   logic [H_W-1:0]      height_eff;
   logic                disp_neg;
   logic [DISP_W-2:0]   disp_mag;
   logic [B_W-1:0]      pix_bin;
   logic [B_W-1:0]      bin;
   logic                bin_ok;
   logic                row_ok;
   logic                col_ok;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= LEVELS_RST;
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_LEVELS: levels_ff <= csr_ch.data[LEVELS_W-1:0];
            CSR_WIDTH:  width_ff  <= csr_ch.data[WIDTH_W-1:0];
            CSR_HEIGHT: height_ff <= csr_ch.data[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // saturate register values into their legal ranges
   always_comb begin
      if (levels_ff < LEVELS_W'(2))         levels_eff = L_W'(2);
      else if (levels_ff > MAX_LEVELS)     levels_eff = L_W'(MAX_LEVELS);
      else                                 levels_eff = L_W'(levels_ff);
      if (width_ff == '0)                  width_eff = W_W'(1);
      else if (width_ff > MAX_COLS)        width_eff = W_W'(MAX_COLS);
      else                                 width_eff = W_W'(width_ff);
      if (height_ff == '0)                 height_eff = H_W'(1);
      else if (height_ff > MAX_ROWS)       height_eff = H_W'(MAX_ROWS);
      else                                 height_eff = H_W'(height_ff);
   end

   assign disp_neg = req_ch.disparity[DISP_W-1];
   assign disp_mag = req_ch.disparity[DISP_W-2:0];
   assign row_ok   = req_ch.row < height_eff;
   assign col_ok   = req_ch.column < width_eff;
   assign bin_ok   = !disp_neg && (disp_mag < levels_eff);

   always_comb begin
      if (disp_neg)                 pix_bin = '0;
      else if (disp_mag >= levels_eff) pix_bin = B_W'(levels_eff - 1'b1);
      else                          pix_bin = B_W'(disp_mag);
   end

   assign bin = (req_ch.kind == KIND_PIXEL) ? pix_bin : B_W'(disp_mag);

   always_comb begin
      unique case (req_ch.kind)
         KIND_CLEAR:  cmd_op = OP_CLEAR;
         KIND_PIXEL:  cmd_op = (row_ok && col_ok) ? OP_BUMP : OP_REJECT;
         KIND_READ_V: cmd_op = (row_ok && bin_ok) ? OP_READ_V : OP_REJECT;
         KIND_READ_U: cmd_op = (col_ok && bin_ok) ? OP_READ_U : OP_REJECT;
         default:     cmd_op = OP_REJECT;
      endcase
   end

   assign cmd_v_addr = VA_W'(int'(req_ch.row) * MAX_LEVELS + int'(bin));
   assign cmd_u_addr = UA_W'(int'(req_ch.column) * MAX_LEVELS + int'(bin));

   assign cmd_valid    = req_ch.valid && !init_busy;
   assign req_ch.ready = cmd_ready && !init_busy;

endmodule

// File: rtl/core/vud_fifo.sv
module vud_fifo #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = vud_pkg::CMD_FIFO_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;
   logic              pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      if (push && !pop)      count_in = CNT_W'(count_ff + 1'b1);
      else if (pop && !push) count_in = CNT_W'(count_ff - 1'b1);
      else                   count_in = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// File: rtl/core/vud_back.sv
module vud_back #(
   parameter int MAX_ROWS   = vud_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS   = vud_pkg::DEF_MAX_COLS,
   parameter int MAX_LEVELS = vud_pkg::DEF_MAX_LEVELS,
   localparam int VA_W = $clog2(MAX_ROWS * MAX_LEVELS),
   localparam int UA_W = $clog2(MAX_COLS * MAX_LEVELS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  vud_pkg::op_type  cmd_op,
   input  logic [VA_W-1:0]  cmd_v_addr,
   input  logic [UA_W-1:0]  cmd_u_addr,
   output logic             init_busy,
   vud_rsp_if.source        rsp_ch
);
   import vud_pkg::*;

   localparam int V_DEPTH = MAX_ROWS * MAX_LEVELS;
   localparam int U_DEPTH = MAX_COLS * MAX_LEVELS;
   localparam int SWEEP   = (V_DEPTH > U_DEPTH) ? V_DEPTH : U_DEPTH;
   localparam int CLR_W   = $clog2(SWEEP);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_CLEAR,
      ST_CLR_RSP
   } state_type;

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [VA_W-1:0]     va_ff, va_in;
   logic [UA_W-1:0]     ua_ff, ua_in;
   logic [CLR_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic                reply_ff, reply_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic                status_ff, status_in;

   logic [COUNT_W-1:0]  v_mem_ff [V_DEPTH];
   logic [COUNT_W-1:0]  u_mem_ff [U_DEPTH];
   logic [COUNT_W-1:0]  v_q_ff;
   logic [COUNT_W-1:0]  u_q_ff;

   logic                out_free;
   logic                rd_en;
   logic                v_we, u_we;
   logic [VA_W-1:0]     v_wa;
   logic [UA_W-1:0]     u_wa;
   logic [COUNT_W-1:0]  v_wd, u_wd;
   logic [COUNT_W-1:0]  v_bump, u_bump;
   logic [COUNT_W-1:0]  sel_count;

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign rd_en     = (state_ff == ST_IDLE) && cmd_valid && out_free;
   assign init_busy = (state_ff == ST_CLEAR) && !reply_ff;
   assign v_bump    = bump_sat(v_q_ff);
   assign u_bump    = bump_sat(u_q_ff);

   always_comb begin
      priority if (op_ff == OP_BUMP)   sel_count = v_bump;
      else if (op_ff == OP_READ_U)     sel_count = u_q_ff;
      else                             sel_count = v_q_ff;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      va_in        = va_ff;
      ua_in        = ua_ff;
      clr_cnt_in   = clr_cnt_ff;
      reply_in     = reply_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      count_in     = count_ff;
      byte_in      = byte_ff;
      status_in    = status_ff;
      cmd_ready    = 1'b0;
      v_we         = 1'b0;
      u_we         = 1'b0;
      v_wa         = va_ff;
      u_wa         = ua_ff;
      v_wd         = v_bump;
      u_wd         = u_bump;
      unique case (state_ff)
         ST_IDLE: begin
            cmd_ready = out_free;
            if (cmd_valid && out_free) begin
               op_in = cmd_op;
               va_in = cmd_v_addr;
               ua_in = cmd_u_addr;
               unique case (cmd_op)
                  OP_CLEAR: begin
                     state_in   = ST_CLEAR;
                     clr_cnt_in = '0;
                     reply_in   = 1'b1;
                  end
                  OP_REJECT: begin
                     rsp_valid_in = 1'b1;
                     count_in     = '0;
                     byte_in      = '0;
                     status_in    = 1'b1;
                  end
                  default: state_in = ST_UPDATE;
               endcase
            end
         end
         ST_UPDATE: begin
            // read data was registered on the way into this state; write back and answer together
            if (out_free) begin
               rsp_valid_in = 1'b1;
               count_in     = sel_count;
               byte_in      = byte_sat(sel_count);
               status_in    = 1'b0;
               v_we         = op_ff == OP_BUMP;
               u_we         = op_ff == OP_BUMP;
               state_in     = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            v_we = clr_cnt_ff < V_DEPTH;
            u_we = clr_cnt_ff < U_DEPTH;
            v_wa = clr_cnt_ff[VA_W-1:0];
            u_wa = clr_cnt_ff[UA_W-1:0];
            v_wd = '0;
            u_wd = '0;
            if (clr_cnt_ff == CLR_W'(SWEEP - 1)) begin
               state_in = reply_ff ? ST_CLR_RSP : ST_IDLE;
            end else begin
               clr_cnt_in = CLR_W'(clr_cnt_ff + 1'b1);
            end
         end
         ST_CLR_RSP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               count_in     = '0;
               byte_in      = '0;
               status_in    = 1'b0;
               reply_in     = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         reply_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         reply_ff     <= reply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff     <= op_in;
      va_ff     <= va_in;
      ua_ff     <= ua_in;
      count_ff  <= count_in;
      byte_ff   <= byte_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (v_we) v_mem_ff[v_wa] <= v_wd;
      if (rd_en) v_q_ff <= v_mem_ff[cmd_v_addr];
   end

   always_ff @(posedge clock) begin
      if (u_we) u_mem_ff[u_wa] <= u_wd;
      if (rd_en) u_q_ff <= u_mem_ff[cmd_u_addr];
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.bin_count = count_ff;
   assign rsp_ch.bin_byte  = byte_ff;
   assign rsp_ch.status    = status_ff;

endmodule

// File: rtl/core/v_u_disparity_histogram_top.sv
// v/u-disparity histogram. Each req word is a clear, a pixel or a bin read, and
// each gives exactly one rsp word. A pixel inside the configured image bumps bin
// (row, clamped disparity) of the v store and bin (column, clamped disparity) of
// the u store, both saturating at 65535, and returns the new v count; pixels
// outside the image and reads outside it or the bin range return status 1 with
// zero counts. In the back end a pixel or read does a registered memory read,
// then update and answer; a rejected word is answered straight from idle. The
// read-modify-write goes through the single read port of each store. A clear
// sweeps both stores one entry a cycle over the depth of the larger store
// (MAX_COLS*MAX_LEVELS = 131072 entries with defaults), then answers. The same
// sweep runs after reset; req is held off until it ends, while csr writes are
// taken at any time. A 2-word command queue sits between the decoder and the
// store engine, and the rsp word is registered, so a pending result does not
// block decode of the next word.
module v_u_disparity_histogram_top #(
   parameter int MAX_ROWS   = vud_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS   = vud_pkg::DEF_MAX_COLS,
   parameter int MAX_LEVELS = vud_pkg::DEF_MAX_LEVELS
) (
   input  logic       clock,
   input  logic       reset,
   vud_req_if.sink    req_ch,
   vud_rsp_if.source  rsp_ch,
   vud_csr_if.sink    csr_ch
);
   import vud_pkg::*;

   localparam int VA_W   = $clog2(MAX_ROWS * MAX_LEVELS);
   localparam int UA_W   = $clog2(MAX_COLS * MAX_LEVELS);
   localparam int OP_W   = $bits(op_type);
   localparam int WORD_W = OP_W + VA_W + UA_W;

   // decoder -> queue
   logic              dec_valid;
   logic              dec_ready;
   op_type            dec_op;
   logic [VA_W-1:0]   dec_v_addr;
   logic [UA_W-1:0]   dec_u_addr;

   // queue -> store engine
   logic              eng_valid;
   logic              eng_ready;
   logic [WORD_W-1:0] eng_word;

   logic              init_busy;

   vud_front #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .MAX_LEVELS (MAX_LEVELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .init_busy  (init_busy),
      .cmd_valid  (dec_valid),
      .cmd_ready  (dec_ready),
      .cmd_op     (dec_op),
      .cmd_v_addr (dec_v_addr),
      .cmd_u_addr (dec_u_addr)
   );

   vud_fifo #(
      .DATA_W (WORD_W),
      .DEPTH  (CMD_FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (dec_valid),
      .push_ready (dec_ready),
      .push_data  ({dec_op, dec_v_addr, dec_u_addr}),
      .pop_valid  (eng_valid),
      .pop_ready  (eng_ready),
      .pop_data   (eng_word)
   );

   vud_back #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .MAX_LEVELS (MAX_LEVELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (eng_valid),
      .cmd_ready  (eng_ready),
      .cmd_op     (op_type'(eng_word[WORD_W-1 -: OP_W])),
      .cmd_v_addr (eng_word[UA_W +: VA_W]),
      .cmd_u_addr (eng_word[UA_W-1:0]),
      .init_busy  (init_busy),
      .rsp_ch     (rsp_ch)
   );

endmodule
